/* sv/bppw_pkg.sv */
package bppw_pkg;

    localparam int unsigned AddrWidth  = 19;
    localparam int unsigned CoordWidth = 8;
    localparam int unsigned ColorWidth = 8;
    localparam int unsigned PlaneWidth = 3;
    localparam int unsigned BaseWidth  = 8;
    localparam int unsigned ModeWidth  = 6;
    localparam int unsigned CfgWidth   = 8;

    typedef enum logic [0:0] {
        CFG_SCREEN_BASE = 1'b0,
        CFG_SCREEN_MODE = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        DEPTH_2BPP    = 2'd0,
        DEPTH_4BPP    = 2'd1,
        DEPTH_8BPP    = 2'd2,
        DEPTH_8BPP_HI = 2'd3
    } depth_t;

    typedef enum logic [1:0] {
        HEIGHT_128    = 2'd0,
        HEIGHT_160    = 2'd1,
        HEIGHT_192    = 2'd2,
        HEIGHT_OBJECT = 2'd3
    } height_t;

    typedef struct packed {
        logic [CoordWidth-1:0] x;
        logic [CoordWidth-1:0] y;
        logic [ColorWidth-1:0] color;
    } req_t;

    typedef struct packed {
        logic [AddrWidth-1:0]  byte_address;
        logic [2:0]            bit_position;
        logic                  bit_value;
        logic [PlaneWidth-1:0] plane;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [AddrWidth-1:0]  row_addr;
        logic [PlaneWidth-1:0] last_plane;
    } job_t;

endpackage

/* sv/bitplane_pixel_plot_writer.sv */
// Plots one pixel into a planar tile screen by issuing one bit-write per bitplane.
// A plot request (x, y, colour) is taken at a rising edge where start is high and
// busy is low. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) writes the screen base and the screen mode; it should only be used
// while no plot is outstanding. cfg_ready is always high.
// Each request gives 2, 4 or 8 results, one per cycle in plane order, each shown
// on result for exactly one cycle with result_valid high; the final one has last set.
// The first result appears once the request has passed the job registers and the result
// register, and the others follow in consecutive cycles.
// The single plane counter steps the write sequence, one write for each of the 2, 4
// or 8 bitplanes that the colour depth selects.
// busy drops in the cycle before the last write of a request appears, so the next
// request is taken then and its writes follow with no gap.
// Reset clears both configuration registers and abandons any writes in progress.
// The receiver has no means to stall the results and must take one every cycle.
module bitplane_pixel_plot_writer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bppw_pkg::req_t                 req,
    output logic                           result_valid,
    output bppw_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [bppw_pkg::CfgWidth-1:0]  cfg_data
);

    logic [bppw_pkg::BaseWidth-1:0]  screen_base_reg;
    logic [bppw_pkg::ModeWidth-1:0]  screen_mode_reg;
    logic                            active_reg;
    logic                            active_next;
    logic [bppw_pkg::PlaneWidth-1:0] plane_reg;
    logic [bppw_pkg::PlaneWidth-1:0] plane_next;
    bppw_pkg::job_t                  job_reg;
    bppw_pkg::job_t                  job_next;
    bppw_pkg::job_t                  job_calc;
    logic [2:0]                      bitpos_reg;
    logic [2:0]                      bitpos_next;
    logic [bppw_pkg::ColorWidth-1:0] color_reg;
    logic [bppw_pkg::ColorWidth-1:0] color_next;
    logic                            result_valid_reg;
    logic                            result_valid_next;
    bppw_pkg::result_t               result_reg;
    bppw_pkg::result_t               result_next;
    logic                            accept;
    logic                            on_last;
    bppw_pkg::cfg_index_t            cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = bppw_pkg::cfg_index_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_base_reg <= '0;
            screen_mode_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_sel)
                bppw_pkg::CFG_SCREEN_BASE:
                begin
                    screen_base_reg <= cfg_data;
                end
                default:
                begin
                    screen_mode_reg <= cfg_data[bppw_pkg::ModeWidth-1:0];
                end
            endcase
        end
    end

    bppw_addr u_addr
    (
        .x           (req.x),
        .y           (req.y),
        .screen_base (screen_base_reg),
        .screen_mode (screen_mode_reg),
        .job         (job_calc)
    );

    assign on_last = (plane_reg == job_reg.last_plane);
    assign busy    = active_reg && !on_last;
    assign accept  = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        plane_next  = plane_reg;
        job_next    = job_reg;
        bitpos_next = bitpos_reg;
        color_next  = color_reg;
        if (accept)
        begin
            active_next = 1'b1;
            plane_next  = '0;
            job_next    = job_calc;
            bitpos_next = ~req.x[2:0];
            color_next  = req.color;
        end
        else if (active_reg)
        begin
            if (on_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                plane_next = plane_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        result_valid_next        = active_reg;
        result_next.byte_address = job_reg.row_addr
                                 + {13'b0, plane_reg[2:1], 4'b0}
                                 + {18'b0, plane_reg[0]};
        result_next.bit_position = bitpos_reg;
        result_next.bit_value    = color_reg[plane_reg];
        result_next.plane        = plane_reg;
        result_next.last         = on_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            plane_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg       <= active_next;
            plane_reg        <= plane_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        bitpos_reg <= bitpos_next;
        color_reg  <= color_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sv/bppw_addr.sv */
module bppw_addr
(
    input  logic [bppw_pkg::CoordWidth-1:0] x,
    input  logic [bppw_pkg::CoordWidth-1:0] y,
    input  logic [bppw_pkg::BaseWidth-1:0]  screen_base,
    input  logic [bppw_pkg::ModeWidth-1:0]  screen_mode,
    output bppw_pkg::job_t                  job
);

    logic [4:0]                    col;
    logic [4:0]                    row;
    logic [9:0]                    tile;
    logic [15:0]                   tile_offset;
    logic [bppw_pkg::PlaneWidth-1:0] last_plane;
    bppw_pkg::height_t             height;
    bppw_pkg::depth_t              depth;

    assign col    = x[7:3];
    assign row    = y[7:3];
    assign height = bppw_pkg::height_t'({screen_mode[5], screen_mode[2]});
    assign depth  = bppw_pkg::depth_t'(screen_mode[1:0]);

    always_comb
    begin
        unique case (height)
            bppw_pkg::HEIGHT_128:
            begin
                tile = {1'b0, col, 4'b0} + {5'b0, row};
            end
            bppw_pkg::HEIGHT_160:
            begin
                tile = {1'b0, col, 4'b0} + {3'b0, col, 2'b0} + {5'b0, row};
            end
            bppw_pkg::HEIGHT_192:
            begin
                tile = {1'b0, col, 4'b0} + {2'b0, col, 3'b0} + {5'b0, row};
            end
            default:
            begin
                tile = {y[7], x[7], y[6:3], x[6:3]};
            end
        endcase
    end

    always_comb
    begin
        unique case (depth)
            bppw_pkg::DEPTH_2BPP:
            begin
                tile_offset = {2'b0, tile, 4'b0};
                last_plane  = 3'd1;
            end
            bppw_pkg::DEPTH_4BPP:
            begin
                tile_offset = {1'b0, tile, 5'b0};
                last_plane  = 3'd3;
            end
            default:
            begin
                tile_offset = {tile, 6'b0};
                last_plane  = 3'd7;
            end
        endcase
    end

    assign job.last_plane = last_plane;
    assign job.row_addr   = {1'b0, screen_base, 10'b0} + {3'b0, tile_offset}
                          + {15'b0, y[2:0], 1'b0};

endmodule

/* test/bitplane_pixel_plot_writer_test.sv */
module bitplane_pixel_plot_writer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned Tiles128   = 32'h10;
    localparam int unsigned Tiles160   = 32'h14;
    localparam int unsigned Tiles192   = 32'h18;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    bppw_pkg::req_t                req = '0;
    logic                          result_valid;
    bppw_pkg::result_t             result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [0:0]                    cfg_index = bppw_pkg::CFG_SCREEN_BASE;
    logic [bppw_pkg::CfgWidth-1:0] cfg_data = '0;

    logic [bppw_pkg::BaseWidth-1:0] screen_base = '0;
    logic [bppw_pkg::ModeWidth-1:0] screen_mode = '0;
    bppw_pkg::result_t              expected_writes[$];
    int unsigned                    sender_idle_pct = 0;
    int unsigned                    plots_sent = 0;
    int unsigned                    writes_checked = 0;
    int unsigned                    error_count = 0;
    int unsigned                    cycle_count = 0;

    bitplane_pixel_plot_writer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_plot(input bppw_pkg::req_t item);
        bppw_pkg::height_t height;
        bppw_pkg::depth_t  depth;
        int unsigned       col;
        int unsigned       row;
        int unsigned       tile;
        int unsigned       shift;
        int unsigned       planes;
        int unsigned       row_addr;
        bppw_pkg::result_t wr;
        height = bppw_pkg::height_t'({screen_mode[5], screen_mode[2]});
        depth  = bppw_pkg::depth_t'(screen_mode[1:0]);
        col    = 32'(item.x) >> 3;
        row    = 32'(item.y) >> 3;
        case (height)
            bppw_pkg::HEIGHT_128: tile = col * Tiles128 + row;
            bppw_pkg::HEIGHT_160: tile = col * Tiles160 + row;
            bppw_pkg::HEIGHT_192: tile = col * Tiles192 + row;
            default:    tile = 32'(item.y[7]) * 32'h200 + 32'(item.x[7]) * 32'h100
                             + 32'(item.y[6:3]) * 32'h10 + 32'(item.x[6:3]);
        endcase
        case (depth)
            bppw_pkg::DEPTH_2BPP:
            begin
                shift  = 4;
                planes = 2;
            end
            bppw_pkg::DEPTH_4BPP:
            begin
                shift  = 5;
                planes = 4;
            end
            default:
            begin
                shift  = 6;
                planes = 8;
            end
        endcase
        row_addr = (32'(screen_base) << 10) + (tile << shift) + 32'(item.y[2:0]) * 2;
        for (int unsigned p = 0; p < planes; p++)
        begin
            wr.byte_address = bppw_pkg::AddrWidth'(row_addr + (p >> 1) * 16 + (p & 1));
            wr.bit_position = ~item.x[2:0];
            wr.bit_value    = item.color[p];
            wr.plane        = bppw_pkg::PlaneWidth'(p);
            wr.last         = (p == planes - 1);
            expected_writes.push_back(wr);
        end
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        bppw_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_writes.size() == 0)
            begin
                $display("%0t: unexpected bit-write, expected none, got %h", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                report_field("byte_address", want.byte_address, result.byte_address);
                report_field("bit_position", want.bit_position, result.bit_position);
                report_field("bit_value", want.bit_value, result.bit_value);
                report_field("plane", want.plane, result.plane);
                report_field("last", want.last, result.last);
                writes_checked++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d writes outstanding.",
                 cycle_count, expected_writes.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_plot(input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] color);
        bppw_pkg::req_t item;
        item = '{x: x, y: y, color: color};
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start <= 1'b1;
        req   <= item;
        predict_plot(item);
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        plots_sent++;
    endtask

    task automatic wait_for_writes();
        start <= 1'b0;
        do
            @(negedge clk);
        while (expected_writes.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input bppw_pkg::cfg_index_t idx,
                             input logic [bppw_pkg::CfgWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        if (idx == bppw_pkg::CFG_SCREEN_BASE)
            screen_base = value;
        else
            screen_mode = value[bppw_pkg::ModeWidth-1:0];
    endtask

    task automatic program_screen(input logic [bppw_pkg::BaseWidth-1:0] base,
                                  input logic [bppw_pkg::ModeWidth-1:0] mode);
        wait_for_writes();
        write_reg(bppw_pkg::CFG_SCREEN_BASE, bppw_pkg::CfgWidth'(base));
        write_reg(bppw_pkg::CFG_SCREEN_MODE, bppw_pkg::CfgWidth'(mode));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_colour_depths();
        for (int d = 0; d < 4; d++)
        begin
            program_screen(8'h00, bppw_pkg::ModeWidth'(d));
            send_plot(8'h00, 8'h00, 8'hFF);
            send_plot(8'hFF, 8'hFF, 8'hA5);
        end
    endtask

    task automatic test_height_modes();
        for (int h = 0; h < 4; h++)
        begin
            program_screen(8'hFF, {h[1], 2'b00, h[0], bppw_pkg::DEPTH_8BPP});
            send_plot(8'hFF, 8'hFF, 8'h5A);
            send_plot(8'h80, 8'h7F, 8'h00);
            send_plot(8'h7F, 8'h80, 8'hC3);
        end
    endtask

    task automatic test_ignored_mode_bits();
        program_screen(8'hFF, 6'h3F);
        send_plot(8'hFF, 8'hFF, 8'hFF);
        program_screen(8'h55, 6'h18);
        send_plot(8'h07, 8'h38, 8'hFC);
        send_plot(8'hF8, 8'hC7, 8'h03);
    endtask

    task automatic test_random_plots(input int unsigned idle_pct, input int unsigned count);
        logic [bppw_pkg::BaseWidth-1:0] base;
        sender_idle_pct = idle_pct;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
            begin
                case ($urandom_range(9))
                    0:       base = '0;
                    1:       base = '1;
                    default: base = bppw_pkg::BaseWidth'($urandom_range(255));
                endcase
                program_screen(base, bppw_pkg::ModeWidth'($urandom_range(63)));
            end
            send_plot(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle_pct = 21;
        test_colour_depths();
        test_height_modes();
        test_ignored_mode_bits();
        test_random_plots(21, 150);
        test_random_plots(45, 150);
        test_random_plots(0, 147);
        wait_for_writes();
        repeat (4) @(posedge clk);
        $display("Sent %0d plot requests and checked %0d bit-writes across all depths,",
                 plots_sent, writes_checked);
        $display("height modes and a spread of screen bases, with and without sender gaps.");
        if (error_count == 0 && expected_writes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
